/* design/tve_pkg.sv */
// Package: shared types, constants and helper functions of the vector encoder.
`default_nettype none

package tve_pkg;

  // Operation codes of an input transaction
  localparam logic [1:0] OP_DRAW   = 2'd0;
  localparam logic [1:0] OP_MOVE   = 2'd1;
  localparam logic [1:0] OP_FORGET = 2'd2;

  // Stream byte codes and tags
  localparam logic [7:0] BYTE_BLANK = 8'o035;
  localparam logic [7:0] TAG_HIGH   = 8'o040;
  localparam logic [7:0] TAG_LOWY   = 8'o140;
  localparam logic [7:0] TAG_LOWX   = 8'o100;

  // Coordinate scaling: (v + 2048) * 780 / 1024
  localparam logic [9:0] SCALE_MUL = 10'd780;

  // Sent-byte memory value that means "unknown"
  localparam logic [5:0] SENT_UNKNOWN = 6'h3f;

  // Burst sizing
  localparam int MAX_BYTES = 10;
  localparam int HDR_BYTES = 6;
  localparam int CNT_W     = $clog2(MAX_BYTES + 2);

  typedef logic [7:0] byte_t;

  // One encoded point: packed byte list and byte count, plus a load strobe
  typedef struct packed {
    logic                        vld;
    logic [MAX_BYTES-1:0][7:0]   bytes;
    logic [CNT_W-1:0]            cnt;
  } burst_t;

  // Scale a signed 12-bit coordinate to 0..3119
  function automatic logic [11:0] scale_coord(input logic [11:0] v);
    logic [11:0] u;
    logic [21:0] prod;
    begin
      u    = {~v[11], v[10:0]};
      prod = u * SCALE_MUL;
      return prod[21:10];
    end
  endfunction

  // |h - s| where s is a 6-bit two's complement memory entry
  function automatic logic [5:0] abs_diff(input logic [4:0] h, input logic [5:0] s);
    logic signed [6:0] d;
    begin
      d = $signed({2'b00, h}) - $signed({s[5], s});
      return d[6] ? 6'(-d) : d[5:0];
    end
  endfunction

  // floor((d + 6) / 12) for d in 0..64
  function automatic logic [2:0] pad_count(input logic [6:0] d);
    begin
      if (d >= 7'd54)      return 3'd5;
      else if (d >= 7'd42) return 3'd4;
      else if (d >= 7'd30) return 3'd3;
      else if (d >= 7'd18) return 3'd2;
      else if (d >= 7'd6)  return 3'd1;
      else                 return 3'd0;
    end
  endfunction

endpackage

`default_nettype wire

/* design/tve_if.sv */
// Interfaces: point input channel and byte output channel.
`default_nettype none

interface tve_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [11:0] x;
  logic signed [11:0] y;

  modport source (output valid, output op, output x, output y, input ready);
  modport sink   (input valid, input op, input x, input y, output ready);
endinterface

interface tve_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

/* design/tve_encode.sv */
// Encoder: input register, sent-byte memory and point-to-byte-list encoding.
`default_nettype none

module tve_encode import tve_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  tve_in_if.sink    in_ch,
  input  logic      burst_free,
  output burst_t    burst
);

  // Input register
  logic               s1_vld_r, s1_vld_nxt;
  logic [1:0]         s1_op_r;
  logic [11:0]        s1_x_r;
  logic [11:0]        s1_y_r;

  // Last-sent memory (6-bit two's complement, all ones = unknown)
  logic [5:0] shy_r, shy_nxt;
  logic [5:0] shx_r, shx_nxt;
  logic [5:0] sly_r, sly_nxt;
  logic [5:0] sex_r, sex_nxt;

  logic        in_acc;
  logic        s1_adv;
  logic        is_pt;
  logic        is_move;
  logic [11:0] sx, sy;
  logic [4:0]  hx, hy, lx, ly;
  logic [3:0]  ex;
  logic        hy_diff, hx_diff, ly_diff, ex_diff;
  logic [6:0]  dsum;
  logic [2:0]  pad;
  logic [HDR_BYTES-1:0]      hdr_en;
  logic [HDR_BYTES-1:0][7:0] hdr_byte;
  logic [2:0]                pos;
  logic [MAX_BYTES-1:0][7:0] list;
  logic [CNT_W-1:0]          total;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign is_move = (s1_op_r == OP_MOVE);
  assign is_pt   = (s1_op_r == OP_DRAW) || is_move;

  // Stage advances when it has no output, or the burst register can take it
  assign s1_adv      = s1_vld_r && (!is_pt || burst_free);
  assign in_ch.ready = !s1_vld_r || s1_adv;

  // Scale and split into stream fields
  always_comb begin
    sx = scale_coord(s1_x_r);
    sy = scale_coord(s1_y_r);
    hx = sx[11:7];
    hy = sy[11:7];
    lx = sx[6:2];
    ly = sy[6:2];
    ex = {sy[1:0], sx[1:0]};
    hy_diff = ({1'b0, hy} != shy_r);
    hx_diff = ({1'b0, hx} != shx_r);
    ly_diff = ({1'b0, ly} != sly_r);
    ex_diff = ({2'b00, ex} != sex_r);
    dsum = {1'b0, abs_diff(hx, shx_r)} + {1'b0, abs_diff(hy, shy_r)};
    pad  = pad_count(dsum);
  end

  // Header candidates in stream order, then compacted into the byte list
  always_comb begin
    hdr_byte[0] = BYTE_BLANK;
    hdr_byte[1] = {3'b000, hy} | TAG_HIGH;
    hdr_byte[2] = {4'b0000, ex} | TAG_LOWY;
    hdr_byte[3] = {3'b000, ly} | TAG_LOWY;
    hdr_byte[4] = {3'b000, hx} | TAG_HIGH;
    hdr_byte[5] = {3'b000, lx} | TAG_LOWX;
    hdr_en[0] = is_move;
    hdr_en[1] = hy_diff;
    hdr_en[2] = ex_diff;
    hdr_en[3] = hx_diff || ex_diff || ly_diff;
    hdr_en[4] = hx_diff;
    hdr_en[5] = 1'b1;

    // padding bytes are zero, so unfilled slots stay zero
    list = '0;
    pos  = 3'd0;
    for (int i = 0; i < HDR_BYTES; i++) begin
      if (hdr_en[i]) begin
        list[{1'b0, pos}] = hdr_byte[i];
        pos = pos + 3'd1;
      end
    end

    total = CNT_W'(pos) + CNT_W'(pad);
    burst.vld   = s1_adv && is_pt;
    burst.bytes = list;
    burst.cnt   = (total > CNT_W'(MAX_BYTES)) ? CNT_W'(MAX_BYTES) : total;
  end

  // Memory update: a point writes the new value, forget marks all unknown
  always_comb begin
    shy_nxt = shy_r;
    shx_nxt = shx_r;
    sly_nxt = sly_r;
    sex_nxt = sex_r;
    if (s1_adv) begin
      if (s1_op_r == OP_FORGET) begin
        shy_nxt = SENT_UNKNOWN;
        shx_nxt = SENT_UNKNOWN;
        sly_nxt = SENT_UNKNOWN;
        sex_nxt = SENT_UNKNOWN;
      end else if (is_pt) begin
        shy_nxt = {1'b0, hy};
        shx_nxt = {1'b0, hx};
        sly_nxt = {1'b0, ly};
        sex_nxt = {2'b00, ex};
      end
    end
  end

  assign s1_vld_nxt = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_r);

  // Control and memory registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      shy_r    <= SENT_UNKNOWN;
      shx_r    <= SENT_UNKNOWN;
      sly_r    <= SENT_UNKNOWN;
      sex_r    <= SENT_UNKNOWN;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      shy_r    <= shy_nxt;
      shx_r    <= shx_nxt;
      sly_r    <= sly_nxt;
      sex_r    <= sex_nxt;
    end
  end

  // Input payload register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r <= in_ch.op;
      s1_x_r  <= in_ch.x;
      s1_y_r  <= in_ch.y;
    end
  end

endmodule

`default_nettype wire

/* design/tve_serial.sv */
// Serializer: holds one encoded byte list, sends a byte per ready cycle.
`default_nettype none

module tve_serial import tve_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  burst_t    burst,
  output logic      burst_free,
  tve_out_if.source out_ch
);

  logic                      vld_r, vld_nxt;
  logic [MAX_BYTES-1:0][7:0] bytes_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [CNT_W-1:0]          idx_r, idx_nxt;
  logic                      take;
  logic                      is_last;

  assign is_last         = ((idx_r + CNT_W'(1)) == cnt_r);
  assign take            = vld_r && out_ch.ready;
  assign burst_free      = !vld_r || (take && is_last);
  assign out_ch.valid    = vld_r;
  assign out_ch.out_byte = bytes_r[idx_r];
  assign out_ch.last     = is_last;

  // Byte pointer and busy flag
  always_comb begin
    vld_nxt = vld_r;
    idx_nxt = idx_r;
    if (burst.vld) begin
      vld_nxt = 1'b1;
      idx_nxt = '0;
    end else if (take) begin
      if (is_last) begin
        vld_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  // Byte list register
  always_ff @(posedge clk) begin
    if (burst.vld) begin
      bytes_r <= burst.bytes;
      cnt_r   <= burst.cnt;
    end
  end

endmodule

`default_nettype wire

/* design/tek4014_vector_encoder_core.sv */
// Top level: vector coordinate encoder, point transactions in, stream bytes out.
//
//  channel | dir | payload             | transaction
//  in_ch   | in  | op, x, y            | one point, move or forget command
//  out_ch  | out | out_byte, last      | one stream byte, last marks end of item
//
// A point is held in the input register, then leaves as 1 to 10 bytes, one per
// cycle while out_ch is ready, from the byte-list register; sustained rate is
// set by that byte count. Forget and undefined ops pass without waiting and
// send nothing. A new transaction is taken while the previous list is still
// being sent. Reset (rst_n low, synchronous) marks all sent-byte memory entries
// unknown. Back-pressure on out_ch holds the current byte; in_ch stalls once
// the input register holds a point and the byte-list register is full.
`default_nettype none

module tek4014_vector_encoder_core import tve_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  tve_in_if.sink    in_ch,
  tve_out_if.source out_ch
);

  burst_t burst;
  logic   burst_free;

  tve_encode u_encode (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .burst_free (burst_free),
    .burst      (burst)
  );

  tve_serial u_serial (
    .clk        (clk),
    .rst_n      (rst_n),
    .burst      (burst),
    .burst_free (burst_free),
    .out_ch     (out_ch)
  );

`ifndef SYNTH
  // A new byte list is loaded only when the previous one is done
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    burst.vld |-> burst_free)
    else $error("byte list loaded over an unfinished one");

  // Every encoded point carries 1..10 bytes
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    burst.vld |-> (burst.cnt != '0) && (burst.cnt <= CNT_W'(MAX_BYTES)))
    else $error("byte count out of range");

  // The first byte of a point is never padding
  a_first_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    burst.vld |-> (burst.bytes[0] != 8'd0))
    else $error("point starts with a padding byte");

  // A loaded list is presented on the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    burst.vld |=> out_ch.valid)
    else $error("loaded byte list not presented");
`endif

endmodule

`default_nettype wire
